FILE: src/kcbt_pkg.sv
// kcbt_pkg: shared types, opcodes and sizes for the keyed credit budget table
// no dependencies; used by every module of the block
`default_nettype none

package kcbt_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam int KEY_W = 32;
    localparam int AMT_W = 16;

    localparam logic [1:0] OP_SET     = 2'd0;
    localparam logic [1:0] OP_REQUEST = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;
    localparam logic [1:0] OP_QUERY   = 2'd3;

    localparam logic [AMT_W-1:0] BUDGET_MAX = {AMT_W{1'b1}};

    typedef struct packed {
        logic [1:0]       opcode;
        logic [KEY_W-1:0] trigger_key;
        logic [AMT_W-1:0] amount;
        logic             force_set;
    } req_t;

    typedef struct packed {
        logic             found;
        logic [AMT_W-1:0] granted;
        logic             table_full;
    } rsp_t;

    // lookup result from the table
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [AMT_W-1:0] budget;
        logic             has_free;
        logic [IDX_W-1:0] free_idx;
    } lookup_t;

    // table update command
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic             set_valid;
        logic             clr_valid;
        logic             write_budget;
        logic [KEY_W-1:0] key;
        logic [AMT_W-1:0] budget;
    } wr_t;

endpackage

`default_nettype wire

FILE: src/kcbt_table.sv
// kcbt_table: entry storage with parallel key compare and free-slot search
// depends on kcbt_pkg
`default_nettype none

module kcbt_table (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [kcbt_pkg::KEY_W-1:0] key,
    input  wire kcbt_pkg::wr_t           wr,
    output kcbt_pkg::lookup_t            lookup
);

    logic [kcbt_pkg::ENTRIES-1:0] valid_reg;
    logic [kcbt_pkg::KEY_W-1:0]   key_reg    [kcbt_pkg::ENTRIES];
    logic [kcbt_pkg::AMT_W-1:0]   budget_reg [kcbt_pkg::ENTRIES];

    logic                         hit;
    logic [kcbt_pkg::IDX_W-1:0]   hit_idx;
    logic                         has_free;
    logic [kcbt_pkg::IDX_W-1:0]   free_idx;

    // downward scan so the lowest index wins
    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        has_free = 1'b0;
        free_idx = '0;
        for (int i = kcbt_pkg::ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (key_reg[i] == key))
            begin
                hit     = 1'b1;
                hit_idx = kcbt_pkg::IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                has_free = 1'b1;
                free_idx = kcbt_pkg::IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        lookup.hit      = hit;
        lookup.hit_idx  = hit_idx;
        lookup.budget   = budget_reg[hit_idx];
        lookup.has_free = has_free;
        lookup.free_idx = free_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            if (wr.set_valid)
            begin
                valid_reg[wr.idx] <= 1'b1;
            end
            else if (wr.clr_valid)
            begin
                valid_reg[wr.idx] <= 1'b0;
            end
        end
    end

    // payload storage, meaningful only while the entry is valid
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            if (wr.set_valid)
            begin
                key_reg[wr.idx] <= wr.key;
            end
            if (wr.write_budget)
            begin
                budget_reg[wr.idx] <= wr.budget;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/kcbt_exec.sv
// kcbt_exec: opcode decode, budget arithmetic and table update command
// depends on kcbt_pkg
`default_nettype none

module kcbt_exec (
    input  wire logic              active,
    input  wire kcbt_pkg::req_t    req,
    input  wire kcbt_pkg::lookup_t lookup,
    output kcbt_pkg::wr_t          wr,
    output kcbt_pkg::rsp_t         rsp
);

    logic [kcbt_pkg::AMT_W:0] release_sum;

    assign release_sum = {1'b0, lookup.budget} + {1'b0, req.amount};

    always_comb
    begin
        wr.en           = 1'b0;
        wr.idx          = lookup.hit_idx;
        wr.set_valid    = 1'b0;
        wr.clr_valid    = 1'b0;
        wr.write_budget = 1'b0;
        wr.key          = req.trigger_key;
        wr.budget       = req.amount;

        rsp.found      = lookup.hit;
        rsp.granted    = '0;
        rsp.table_full = 1'b0;

        unique case (req.opcode)
            kcbt_pkg::OP_SET:
            begin
                if (!lookup.hit)
                begin
                    if (lookup.has_free)
                    begin
                        wr.en           = active;
                        wr.idx          = lookup.free_idx;
                        wr.set_valid    = 1'b1;
                        wr.write_budget = 1'b1;
                    end
                    else
                    begin
                        rsp.table_full = 1'b1;
                    end
                end
                else if (req.amount == '0)
                begin
                    wr.en        = active;
                    wr.clr_valid = 1'b1;
                end
                else if (req.force_set || (lookup.budget > req.amount))
                begin
                    wr.en           = active;
                    wr.write_budget = 1'b1;
                end
            end
            kcbt_pkg::OP_REQUEST:
            begin
                if (!lookup.hit)
                begin
                    rsp.granted = req.amount;
                end
                else if (lookup.budget >= req.amount)
                begin
                    rsp.granted     = req.amount;
                    wr.en           = active;
                    wr.write_budget = 1'b1;
                    wr.budget       = lookup.budget - req.amount;
                end
                else
                begin
                    rsp.granted     = lookup.budget;
                    wr.en           = active;
                    wr.write_budget = 1'b1;
                    wr.budget       = '0;
                end
            end
            kcbt_pkg::OP_RELEASE:
            begin
                if (lookup.hit)
                begin
                    wr.en           = active;
                    wr.write_budget = 1'b1;
                    // saturate at the top of the budget range
                    wr.budget = release_sum[kcbt_pkg::AMT_W] ? kcbt_pkg::BUDGET_MAX
                                                             : release_sum[kcbt_pkg::AMT_W-1:0];
                end
            end
            kcbt_pkg::OP_QUERY:
            begin
                if (lookup.hit)
                begin
                    rsp.granted = lookup.budget;
                end
            end
            default:
            begin
                rsp.granted = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/keyed_credit_budget_table_unit.sv
// keyed_credit_budget_table_unit: request register, table lookup/update, result register
// timing: the request register feeds lookup and update; done and the result are then registered together
// throughput: one request per cycle; busy stays low, and lookup and update never stall
// back-to-back requests see the table as left by the previous request
// reset: all entries become empty, no result pending; the receiver cannot stall
// depends on kcbt_pkg, kcbt_table, kcbt_exec
`default_nettype none

module keyed_credit_budget_table_unit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire kcbt_pkg::req_t req,
    output logic                done,
    output kcbt_pkg::rsp_t      rsp
);

    logic              req_valid_reg;
    kcbt_pkg::req_t    req_reg;
    logic              done_reg;
    kcbt_pkg::rsp_t    rsp_reg;

    kcbt_pkg::lookup_t lookup;
    kcbt_pkg::wr_t     wr;
    kcbt_pkg::rsp_t    rsp_next;

    // every cycle can take a request
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
            done_reg      <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= req;
        end
        if (req_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    kcbt_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .key    (req_reg.trigger_key),
        .wr     (wr),
        .lookup (lookup)
    );

    kcbt_exec u_exec (
        .active (req_valid_reg),
        .req    (req_reg),
        .lookup (lookup),
        .wr     (wr),
        .rsp    (rsp_next)
    );

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire
